// ===== rtl/tcs_pkg.sv =====
// ============================================================================
// Text console scrollback package
// Shared geometry, field widths, codes, and controller/datapath structs.
// ============================================================================
package tcs_pkg;

  // Screen geometry and scrollback depth.
  localparam int COLS         = 80;
  localparam int ROWS         = 25;
  localparam int PAGES        = 100;
  localparam int LINES_TOTAL  = ROWS * PAGES;
  localparam int SCREEN_CELLS = COLS * ROWS;
  localparam int TEXT_CELLS   = COLS * ROWS * PAGES;

  // Internal widths derived from the geometry.
  localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int PAGE_W = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int LINE_W = (LINES_TOTAL > 1) ? $clog2(LINES_TOTAL) : 1;
  localparam int SCR_AW = $clog2(SCREEN_CELLS);
  localparam int TXT_AW = $clog2(TEXT_CELLS);

  // Fixed field widths of the request and result channels.
  localparam int OPCODE_W      = 3;
  localparam int CHAR_W        = 8;
  localparam int READ_ROW_W    = 5;
  localparam int READ_COL_W    = 7;
  localparam int COLOR_W       = 8;
  localparam int CURSOR_COL_W  = 7;
  localparam int CURSOR_LINE_W = 12;
  localparam int SHOWN_PAGE_W  = 7;

  // Character codes and the color after reset.
  localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'h08;
  localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'h0A;
  localparam logic [CHAR_W-1:0]  CH_RETURN    = 8'h0D;
  localparam logic [CHAR_W-1:0]  CH_SPACE     = 8'h20;
  localparam logic [COLOR_W-1:0] COLOR_RESET  = 8'h09;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CHAR         = 3'd0,
    OP_PAGE_UP      = 3'd1,
    OP_PAGE_DOWN    = 3'd2,
    OP_CURSOR_RESET = 3'd3,
    OP_READ_CELL    = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_CLEAR,
    ST_CHAR,
    ST_REDRAW,
    ST_REDRAW_END,
    ST_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic init_step;
    logic accept;
    logic view_sync;
    logic view_dec;
    logic view_inc;
    logic cur_zero;
    logic rd_cell;
    logic sweep_start;
    logic clear_step;
    logic redraw_step;
    logic char_exec;
    logic out_load;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic init_last;
    logic sweep_last;
    logic page_differs;
    logic out_free;
  } dp_status_t;

endpackage

// ===== rtl/tcs_chan_if.sv =====
// ============================================================================
// Text console scrollback channels
// Valid/ready request and result channels with their payload fields.
// ============================================================================
interface tcs_req_if;
  import tcs_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OPCODE_W-1:0]   opcode;
  logic [CHAR_W-1:0]     char_code;
  logic [READ_ROW_W-1:0] read_row;
  logic [READ_COL_W-1:0] read_col;

  modport source (output valid, output opcode, output char_code, output read_row,
                  output read_col, input ready);
  modport sink   (input valid, input opcode, input char_code, input read_row,
                  input read_col, output ready);
endinterface

interface tcs_rsp_if;
  import tcs_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [CHAR_W-1:0]        cell_char;
  logic [COLOR_W-1:0]       cell_color;
  logic [CURSOR_COL_W-1:0]  cursor_col;
  logic [CURSOR_LINE_W-1:0] cursor_line;
  logic [SHOWN_PAGE_W-1:0]  shown_page;

  modport source (output valid, output cell_char, output cell_color, output cursor_col,
                  output cursor_line, output shown_page, input ready);
  modport sink   (input valid, input cell_char, input cell_color, input cursor_col,
                  input cursor_line, input shown_page, output ready);
endinterface

// ===== rtl/tcs_ctrl.sv =====
// ============================================================================
// Text console scrollback controller
// Sequences reset clearing, screen sweeps, character updates and responses.
// ============================================================================
module tcs_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [tcs_pkg::OPCODE_W-1:0]  in_opcode,
  output logic                          in_ready,
  input  tcs_pkg::dp_status_t           st,
  output tcs_pkg::ctrl_cmd_t            cmd
);
  import tcs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (st.init_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          case (op_t'(in_opcode))
            OP_CHAR: begin
              if (st.page_differs) begin
                cmd.view_sync   = 1'b1;
                cmd.sweep_start = 1'b1;
                state_nxt       = ST_CLEAR;
              end else begin
                state_nxt = ST_CHAR;
              end
            end
            OP_PAGE_UP: begin
              cmd.view_dec    = 1'b1;
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_REDRAW;
            end
            OP_PAGE_DOWN: begin
              cmd.view_inc    = 1'b1;
              cmd.sweep_start = 1'b1;
              state_nxt       = ST_REDRAW;
            end
            OP_CURSOR_RESET: begin
              cmd.cur_zero = 1'b1;
              state_nxt    = ST_RESP;
            end
            OP_READ_CELL: begin
              cmd.rd_cell = 1'b1;
              state_nxt   = ST_RESP;
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (st.sweep_last) begin
          state_nxt = ST_CHAR;
        end
      end
      ST_CHAR: begin
        cmd.char_exec = 1'b1;
        state_nxt     = ST_RESP;
      end
      ST_REDRAW: begin
        cmd.redraw_step = 1'b1;
        if (st.sweep_last) begin
          state_nxt = ST_REDRAW_END;
        end
      end
      ST_REDRAW_END: begin
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_INIT;
      end
    endcase
  end

  // A character on another page must clear the screen first.
  a_char_clears_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_valid && in_opcode == OP_CHAR && st.page_differs)
    |=> state_r == ST_CLEAR)
    else $error("page change on character did not start a screen clear");

  // The character update only runs with the view on the cursor's page.
  a_char_on_view: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CHAR |-> !st.page_differs)
    else $error("character update while view is off the cursor page");

  // The redraw drain cycle always hands over to the response.
  a_redraw_drains: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_REDRAW_END |=> state_r == ST_RESP)
    else $error("redraw drain did not lead to the response");

endmodule

// ===== rtl/tcs_dp.sv =====
// ============================================================================
// Text console scrollback datapath
// Cursor and view registers, text and screen stores, sweep counter, result.
// ============================================================================
module tcs_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  tcs_pkg::ctrl_cmd_t                 cmd,
  output tcs_pkg::dp_status_t                st,
  input  logic                               cfg_we,
  input  logic [tcs_pkg::COLOR_W-1:0]        cfg_wdata,
  input  logic [tcs_pkg::CHAR_W-1:0]         in_char_code,
  input  logic [tcs_pkg::READ_ROW_W-1:0]     in_read_row,
  input  logic [tcs_pkg::READ_COL_W-1:0]     in_read_col,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [tcs_pkg::CHAR_W-1:0]         out_cell_char,
  output logic [tcs_pkg::COLOR_W-1:0]        out_cell_color,
  output logic [tcs_pkg::CURSOR_COL_W-1:0]   out_cursor_col,
  output logic [tcs_pkg::CURSOR_LINE_W-1:0]  out_cursor_line,
  output logic [tcs_pkg::SHOWN_PAGE_W-1:0]   out_shown_page
);
  import tcs_pkg::*;

  localparam logic [TXT_AW-1:0] COLS_T   = TXT_AW'(COLS);
  localparam logic [SCR_AW-1:0] COLS_S   = SCR_AW'(COLS);
  localparam logic [TXT_AW-1:0] SCREEN_T = TXT_AW'(SCREEN_CELLS);

  logic [COL_W-1:0]   cur_x_r,    cur_x_nxt;
  logic [LINE_W-1:0]  cur_y_r,    cur_y_nxt;
  logic [ROW_W-1:0]   cur_row_r,  cur_row_nxt;
  logic [PAGE_W-1:0]  cur_page_r, cur_page_nxt;
  logic [PAGE_W-1:0]  view_r,     view_nxt;
  logic [COLOR_W-1:0] color_r;
  logic [CHAR_W-1:0]  char_r;
  logic               cell_en_r;
  logic [TXT_AW-1:0]  cnt_r;
  logic               rd_pend_r;
  logic [SCR_AW-1:0]  wr_idx_r;
  logic [CHAR_W-1:0]  text_q_r;
  logic [15:0]        screen_q_r;
  logic               out_valid_r;
  logic [CHAR_W-1:0]        out_char_r;
  logic [COLOR_W-1:0]       out_color_r;
  logic [CURSOR_COL_W-1:0]  out_col_r;
  logic [CURSOR_LINE_W-1:0] out_line_r;
  logic [SHOWN_PAGE_W-1:0]  out_page_r;

  logic [CHAR_W-1:0] text_mem [TEXT_CELLS];
  logic [15:0]       scr_mem  [SCREEN_CELLS];

  // Line step forward with wrap at the end of the store.
  logic               y_last;
  logic [LINE_W-1:0]  adv_y;
  logic [ROW_W-1:0]   adv_row;
  logic [PAGE_W-1:0]  adv_page;
  // Line step back, held at line zero.
  logic [LINE_W-1:0]  ret_y;
  logic [ROW_W-1:0]   ret_row;
  logic [PAGE_W-1:0]  ret_page;

  logic               is_nl, is_bs;
  logic [COL_W-1:0]   wx;
  logic [LINE_W-1:0]  wy;
  logic [ROW_W-1:0]   wrow;
  logic [PAGE_W-1:0]  wpage;
  logic [CHAR_W-1:0]  wchar;
  logic               char_we;
  logic [TXT_AW-1:0]  char_taddr;
  logic [SCR_AW-1:0]  char_saddr;

  logic               txt_we;
  logic [TXT_AW-1:0]  txt_waddr, txt_raddr;
  logic [CHAR_W-1:0]  txt_wdata;
  logic               scr_we;
  logic [SCR_AW-1:0]  scr_waddr, scr_raddr;
  logic [15:0]        scr_wdata;
  logic               rd_ok;

  always_comb begin
    y_last   = (cur_y_r == LINE_W'(LINES_TOTAL - 1));
    adv_y    = y_last ? '0 : cur_y_r + 1'b1;
    adv_row  = '0;
    adv_page = '0;
    if (!y_last) begin
      if (cur_row_r == ROW_W'(ROWS - 1)) begin
        adv_page = cur_page_r + 1'b1;
      end else begin
        adv_row  = cur_row_r + 1'b1;
        adv_page = cur_page_r;
      end
    end

    ret_y    = cur_y_r;
    ret_row  = cur_row_r;
    ret_page = cur_page_r;
    if (cur_y_r != '0) begin
      ret_y = cur_y_r - 1'b1;
      if (cur_row_r == '0) begin
        ret_row  = ROW_W'(ROWS - 1);
        ret_page = cur_page_r - 1'b1;
      end else begin
        ret_row = cur_row_r - 1'b1;
      end
    end

    is_nl = (char_r == CH_NEWLINE) || (char_r == CH_RETURN);
    is_bs = (char_r == CH_BACKSPACE);

    // Cell touched by this character: backspace writes one cell back.
    wx    = cur_x_r;
    wy    = cur_y_r;
    wrow  = cur_row_r;
    wpage = cur_page_r;
    wchar = char_r;
    if (is_bs) begin
      wchar = CH_SPACE;
      if (cur_x_r == '0) begin
        wx    = COL_W'(COLS - 1);
        wy    = ret_y;
        wrow  = ret_row;
        wpage = ret_page;
      end else begin
        wx = cur_x_r - 1'b1;
      end
    end
    char_we    = cmd.char_exec && !is_nl;
    char_taddr = TXT_AW'(wy) * COLS_T + TXT_AW'(wx);
    char_saddr = SCR_AW'(wrow) * COLS_S + SCR_AW'(wx);

    cur_x_nxt    = cur_x_r;
    cur_y_nxt    = cur_y_r;
    cur_row_nxt  = cur_row_r;
    cur_page_nxt = cur_page_r;
    if (cmd.cur_zero) begin
      cur_x_nxt    = '0;
      cur_y_nxt    = '0;
      cur_row_nxt  = '0;
      cur_page_nxt = '0;
    end else if (cmd.char_exec) begin
      if (is_bs) begin
        cur_x_nxt    = wx;
        cur_y_nxt    = wy;
        cur_row_nxt  = wrow;
        cur_page_nxt = wpage;
      end else if (is_nl || cur_x_r == COL_W'(COLS - 1)) begin
        cur_x_nxt    = '0;
        cur_y_nxt    = adv_y;
        cur_row_nxt  = adv_row;
        cur_page_nxt = adv_page;
      end else begin
        cur_x_nxt = cur_x_r + 1'b1;
      end
    end

    view_nxt = view_r;
    if (cmd.view_sync) begin
      view_nxt = cur_page_r;
    end else if (cmd.view_dec && view_r != '0) begin
      view_nxt = view_r - 1'b1;
    end else if (cmd.view_inc && view_r < cur_page_r) begin
      view_nxt = view_r + 1'b1;
    end
  end

  // Store port selection.
  always_comb begin
    txt_we    = cmd.init_step || char_we;
    txt_waddr = cmd.init_step ? cnt_r : char_taddr;
    txt_wdata = cmd.init_step ? '0 : wchar;
    txt_raddr = TXT_AW'(view_r) * SCREEN_T + cnt_r;

    scr_we    = (cmd.init_step && (32'(cnt_r) < 32'(SCREEN_CELLS))) || cmd.clear_step ||
                char_we || rd_pend_r;
    scr_waddr = char_saddr;
    scr_wdata = {color_r, wchar};
    if (cmd.init_step || cmd.clear_step) begin
      scr_waddr = cnt_r[SCR_AW-1:0];
      scr_wdata = '0;
    end else if (rd_pend_r) begin
      scr_waddr = wr_idx_r;
      scr_wdata = {color_r, text_q_r};
    end

    rd_ok     = (32'(in_read_row) < 32'(ROWS)) && (32'(in_read_col) < 32'(COLS));
    scr_raddr = rd_ok ? SCR_AW'(in_read_row) * COLS_S + SCR_AW'(in_read_col) : '0;
  end

  always_ff @(posedge clk) begin
    if (txt_we) begin
      text_mem[txt_waddr] <= txt_wdata;
    end
    if (cmd.redraw_step) begin
      text_q_r <= text_mem[txt_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (scr_we) begin
      scr_mem[scr_waddr] <= scr_wdata;
    end
    if (cmd.rd_cell) begin
      screen_q_r <= scr_mem[scr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      cur_row_r   <= '0;
      cur_page_r  <= '0;
      view_r      <= '0;
      color_r     <= COLOR_RESET;
      cnt_r       <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_x_r    <= cur_x_nxt;
      cur_y_r    <= cur_y_nxt;
      cur_row_r  <= cur_row_nxt;
      cur_page_r <= cur_page_nxt;
      view_r     <= view_nxt;
      if (cfg_we) begin
        color_r <= cfg_wdata;
      end
      if (cmd.sweep_start) begin
        cnt_r <= '0;
      end else if (cmd.init_step || cmd.clear_step || cmd.redraw_step) begin
        cnt_r <= cnt_r + 1'b1;
      end
      rd_pend_r <= cmd.redraw_step;
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    wr_idx_r <= cnt_r[SCR_AW-1:0];
    if (cmd.accept) begin
      char_r    <= in_char_code;
      cell_en_r <= cmd.rd_cell && rd_ok;
    end
    if (cmd.out_load) begin
      out_char_r  <= cell_en_r ? screen_q_r[7:0] : '0;
      out_color_r <= cell_en_r ? screen_q_r[15:8] : '0;
      out_col_r   <= CURSOR_COL_W'(cur_x_r);
      out_line_r  <= CURSOR_LINE_W'(cur_y_r);
      out_page_r  <= SHOWN_PAGE_W'(view_r);
    end
  end

  always_comb begin
    st.init_last    = (cnt_r == TXT_AW'(TEXT_CELLS - 1));
    st.sweep_last   = (cnt_r == TXT_AW'(SCREEN_CELLS - 1));
    st.page_differs = (cur_page_r != view_r);
    st.out_free     = !out_valid_r || out_ready;
  end

  assign out_valid       = out_valid_r;
  assign out_cell_char   = out_char_r;
  assign out_cell_color  = out_color_r;
  assign out_cursor_col  = out_col_r;
  assign out_cursor_line = out_line_r;
  assign out_shown_page  = out_page_r;

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_x_r) < 32'(COLS))
    else $error("cursor column left the screen width");

  // The split line (page, row) must always agree with the line number.
  a_line_split: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cur_y_r) == 32'(cur_page_r) * 32'(ROWS) + 32'(cur_row_r))
    else $error("cursor page and row disagree with cursor line");

  // A redraw read is always followed by its screen write in the next cycle.
  a_redraw_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.redraw_step |=> scr_we && rd_pend_r)
    else $error("redraw read not followed by a screen write");

endmodule

// ===== rtl/text_console_scrollback_unit.sv =====
// ============================================================================
// Text console scrollback unit
// 80x25 text console with a 100-page scrollback store and a shown page.
// ============================================================================
//
//  Channel  | Direction | Handshake     | Payload
//  ---------+-----------+---------------+------------------------------------------
//  in_ch    | in        | valid / ready | opcode, char_code, read_row, read_col
//  out_ch   | out       | valid / ready | cell_char, cell_color, cursor_col,
//           |           |               | cursor_line, shown_page
//  cfg      | in        | cfg_we        | cfg_wdata (text color)
//
// One request is worked on at a time. Cursor reset, cell reads and unused
// opcodes go straight to the response, and characters on the shown page
// pass through the character update first. A character on another page adds
// a clear of the 2000 screen cells, and page up or page down redraw the
// screen: the redraw streams the 2000 screen cells through the single read
// port of the text store, one cell a cycle.
// After reset a clearing pass writes zero to all 200000 text cells (and the
// 2000 screen cells alongside), so no request is taken until the pass ends.
// The result sits in an output register; a stalled result channel holds
// only the next response, and the next request is accepted meanwhile.
//
module text_console_scrollback_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  tcs_req_if.sink                      in_ch,
  tcs_rsp_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [tcs_pkg::COLOR_W-1:0]  cfg_wdata
);
  import tcs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // The controller owns the request handshake and sequences every step.
  tcs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  // The datapath holds the cursor, view page, text color, both stores and
  // the result register that drives the result channel.
  tcs_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_char_code    (in_ch.char_code),
    .in_read_row     (in_ch.read_row),
    .in_read_col     (in_ch.read_col),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_cell_char   (out_ch.cell_char),
    .out_cell_color  (out_ch.cell_color),
    .out_cursor_col  (out_ch.cursor_col),
    .out_cursor_line (out_ch.cursor_line),
    .out_shown_page  (out_ch.shown_page)
  );

endmodule
